@@ rtl/pee_pkg.sv @@
package pee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam int Q_W    = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;

    // |a| << 16 over |b|: one quotient bit per step
    localparam int DIV_W     = Q_W + 16;
    localparam int DIV_STEPS = DIV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // signed intermediate wide enough for any sum, shifted product or quotient
    localparam int WIDE_W = DIV_W + 1;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STAT_W-1:0] ST_SATURATED = 3'd4;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [WIDE_W-1:0] t_wide;

    function automatic t_wide widen_q(input t_q v);
        widen_q = {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
    endfunction

endpackage

@@ rtl/postfix_expression_evaluator.sv @@
// Postfix evaluator over signed Q16.16 words, one token per input word.
// Input channel: i_valid / o_ready carry i_operation and i_value. Push puts
// i_value on a 16-entry operand stack; add, subtract, multiply and divide pop
// two entries (the older one is the left operand) and push the clamped result;
// finish emits the top entry and the sticky status on o_valid / i_ready, then
// empties the stack. Codes six and seven are dropped.
// Arithmetic words read both operands from the stack, execute, then write the
// saturated result back; multiply adds a product-shift step, divide runs the
// radix-2 restoring divider (divide by zero skips it), and finish reads the
// top entry, then waits for the output slot if it is still occupied.
// o_ready is high only while the sequencer is idle, one word at a time.
// The result register holds a finished word until it is taken; the block
// keeps taking pushes and arithmetic meanwhile and waits at a second finish.
// Reset (synchronous, active low) empties the stack, clears the status and
// drops any pending result; stack contents need no clearing.
module postfix_expression_evaluator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pee_pkg::OP_W-1:0]     i_operation,
    input  logic signed [pee_pkg::Q_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [pee_pkg::Q_W-1:0] o_result,
    output logic [pee_pkg::STAT_W-1:0]   o_status
);
    import pee_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD_B    = 4'd1;
    localparam logic [3:0] S_RD_A    = 4'd2;
    localparam logic [3:0] S_GET_A   = 4'd3;
    localparam logic [3:0] S_EXEC    = 4'd4;
    localparam logic [3:0] S_MUL2    = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_DIVEND  = 4'd7;
    localparam logic [3:0] S_SAT     = 4'd8;
    localparam logic [3:0] S_FIN_RD  = 4'd9;
    localparam logic [3:0] S_FIN_OUT = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [STAT_W-1:0] r_err, n_err;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_a_zero, n_a_zero;
    logic              r_b_zero, n_b_zero;
    t_q                r_a, n_a;
    t_q                r_b, n_b;
    logic signed [2*Q_W-1:0] r_prod, n_prod;
    t_wide             r_wide, n_wide;
    logic [Q_W-1:0]    r_rem, n_rem;
    logic [Q_W-1:0]    r_div, n_div;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_o_valid, n_o_valid;
    t_q                r_o_result, n_o_result;
    logic [STAT_W-1:0] r_o_status, n_o_status;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [Q_W-1:0]    ram_wdata, ram_rdata;

    logic              accept;
    logic [SP_W-1:0]   sp_dec;
    logic [Q_W:0]      rem_sh;
    logic [Q_W+1:0]    rem_diff;
    logic [Q_W-1:0]    mag_a, mag_b;
    logic              wide_ovf;
    t_q                sat_val;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;
    assign o_status = r_o_status;

    assign sp_dec    = r_sp - SP_W'(1);
    assign ram_waddr = r_sp[IDX_W-1:0];
    assign ram_raddr = sp_dec[IDX_W-1:0];

    assign mag_a = r_a[Q_W-1] ? Q_W'(-r_a) : Q_W'(r_a);
    assign mag_b = r_b[Q_W-1] ? Q_W'(-r_b) : Q_W'(r_b);

    // restoring divider step
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_div};

    // value fits Q16.16 only if the bits from the Q sign up are all equal
    assign wide_ovf = !((&r_wide[WIDE_W-1:Q_W-1]) || !(|r_wide[WIDE_W-1:Q_W-1]));
    assign sat_val  = wide_ovf ? (r_wide[WIDE_W-1] ? Q_MIN : Q_MAX) : r_wide[Q_W-1:0];

    pee_ram #(
        .WIDTH(Q_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_sp       = r_sp;
        n_err      = r_err;
        n_op       = r_op;
        n_a_zero   = r_a_zero;
        n_b_zero   = r_b_zero;
        n_a        = r_a;
        n_b        = r_b;
        n_prod     = r_prod;
        n_wide     = r_wide;
        n_rem      = r_rem;
        n_div      = r_div;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_neg      = r_neg;
        n_o_valid  = r_o_valid;
        n_o_result = r_o_result;
        n_o_status = r_o_status;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = i_value;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_operation;
                    if (i_operation == OP_PUSH) begin
                        if (r_sp < SP_W'(STACK_DEPTH)) begin
                            ram_we = 1'b1;
                            n_sp   = r_sp + SP_W'(1);
                        end else if (r_err == ST_OK) begin
                            n_err = ST_OVERFLOW;
                        end
                    end else if (i_operation == OP_FINISH) begin
                        n_state = S_FIN_RD;
                    end else if (i_operation <= OP_DIV) begin
                        n_state = S_RD_B;
                    end
                end
            end
            S_RD_B: begin
                n_b_zero = (r_sp == '0);
                if (r_sp == '0) begin
                    if (r_err == ST_OK) n_err = ST_UNDERFLOW;
                end else begin
                    ram_re = 1'b1;
                    n_sp   = sp_dec;
                end
                n_state = S_RD_A;
            end
            S_RD_A: begin
                n_b      = r_b_zero ? '0 : t_q'(ram_rdata);
                n_a_zero = (r_sp == '0);
                if (r_sp == '0) begin
                    if (r_err == ST_OK) n_err = ST_UNDERFLOW;
                end else begin
                    ram_re = 1'b1;
                    n_sp   = sp_dec;
                end
                n_state = S_GET_A;
            end
            S_GET_A: begin
                n_a     = r_a_zero ? '0 : t_q'(ram_rdata);
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_SAT;
                if (r_op == OP_ADD) begin
                    n_wide = widen_q(r_a) + widen_q(r_b);
                end else if (r_op == OP_SUB) begin
                    n_wide = widen_q(r_a) - widen_q(r_b);
                end else if (r_op == OP_MUL) begin
                    n_prod  = r_a * r_b;
                    n_state = S_MUL2;
                end else if (r_b == '0) begin
                    if (r_err == ST_OK) n_err = ST_DIVZERO;
                    n_wide = widen_q(r_a[Q_W-1] ? Q_MIN : Q_MAX);
                end else begin
                    n_quo   = {mag_a, 16'h0000};
                    n_div   = mag_b;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg   = r_a[Q_W-1] ^ r_b[Q_W-1];
                    n_state = S_DIV;
                end
            end
            S_MUL2: begin
                // arithmetic shift rounds toward minus infinity
                n_wide  = {{(WIDE_W-(2*Q_W-16)){r_prod[2*Q_W-1]}}, r_prod[2*Q_W-1:16]};
                n_state = S_SAT;
            end
            S_DIV: begin
                if (!rem_diff[Q_W+1]) begin
                    n_rem = rem_diff[Q_W-1:0];
                    n_quo = {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[Q_W-1:0];
                    n_quo = {r_quo[DIV_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DIVEND;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DIVEND: begin
                n_wide  = r_neg ? -t_wide'({1'b0, r_quo}) : t_wide'({1'b0, r_quo});
                n_state = S_SAT;
            end
            S_SAT: begin
                // two pops came first, so the push always fits
                if (wide_ovf && r_err == ST_OK) n_err = ST_SATURATED;
                ram_we    = 1'b1;
                ram_wdata = sat_val;
                n_sp      = r_sp + SP_W'(1);
                n_state   = S_IDLE;
            end
            S_FIN_RD: begin
                n_a_zero = (r_sp == '0);
                if (r_sp == '0) begin
                    if (r_err == ST_OK) n_err = ST_UNDERFLOW;
                end else begin
                    ram_re = 1'b1;
                end
                n_state = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                // hold until the output slot is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_result = r_a_zero ? '0 : t_q'(ram_rdata);
                    n_o_status = r_err;
                    n_sp       = '0;
                    n_err      = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_err     <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_err     <= n_err;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_a_zero   <= n_a_zero;
        r_b_zero   <= n_b_zero;
        r_a        <= n_a;
        r_b        <= n_b;
        r_prod     <= n_prod;
        r_wide     <= n_wide;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_o_result <= n_o_result;
        r_o_status <= n_o_status;
    end

endmodule

@@ rtl/pee_ram.sv @@
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
